// File: rtl/bfsa_pkg.sv
package bfsa_pkg;

	// Result codes
	localparam logic [2:0] STAT_REUSED  = 3'd0;
	localparam logic [2:0] STAT_NEW     = 3'd1;
	localparam logic [2:0] STAT_FULL    = 3'd2;
	localparam logic [2:0] STAT_UNKNOWN = 3'd3;
	localparam logic [2:0] STAT_ZERO    = 3'd4;

	// Request function codes
	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FREE_RD,
		ST_COMMIT,
		ST_RESP
	} alloc_state_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [9:0]  slot;
		logic [31:0] granted_size;
	} res_t;

endpackage

// File: rtl/best_fit_slot_allocator.sv
// Best-fit slot allocator. Each request is one of two functions. Allocate
// (func 0) scans the slot table and grants the free slot whose recorded size
// is the smallest that still covers req_size, lowest index on a tie; failing
// that it claims the next never-used slot and records req_size there, or
// answers pool full. Free (func 1) clears the busy flag of the slot named by
// handle. Every request yields exactly one result on the output channel.
// Slots are claimed strictly in index order, so a fill count marks which
// entries are in use; no clearing pass is needed after reset and the block
// takes requests from the first cycle. An allocate scans the F slots claimed
// since reset (at most SLOTS), reading one entry a cycle through the single
// table port, then commits and responds; with no slot claimed yet the scan
// reads nothing. A free issues its read in the accept cycle, then writes
// back and responds; a zero-size request, an oversized request or a free
// of an unknown handle goes straight to the response. One request is in
// work at a time; the output register lets the next request enter while
// a result waits to be taken.
module best_fit_slot_allocator
	import bfsa_pkg::*;
#(
	parameter int SLOTS     = 1024,
	parameter int SIZE_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        func,
	input  logic [31:0] req_size,
	input  logic [9:0]  handle,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [9:0]  slot,
	output logic [31:0] granted_size
);

	localparam int SW = $clog2(SLOTS);

	logic [SW-1:0]      mem_addr;
	logic               mem_we;
	logic [SIZE_BITS:0] mem_wdata;
	logic [SIZE_BITS:0] mem_rdata;

	logic res_valid;
	logic res_ready;
	res_t res;

	logic out_valid_q;
	res_t out_q;

	// Slot table: {busy, size} per entry
	bfsa_mem #(
		.DEPTH (SLOTS),
		.WIDTH (SIZE_BITS + 1),
		.AW    (SW)
	) u_mem (
		.clk   (clk),
		.addr  (mem_addr),
		.we    (mem_we),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	bfsa_ctrl #(
		.SLOTS     (SLOTS),
		.SIZE_BITS (SIZE_BITS),
		.SW        (SW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.func      (func),
		.req_size  (req_size),
		.handle    (handle),
		.mem_addr  (mem_addr),
		.mem_we    (mem_we),
		.mem_wdata (mem_wdata),
		.mem_rdata (mem_rdata),
		.res_ready (res_ready),
		.res_valid (res_valid),
		.res       (res)
	);

	// The output register is free when empty or being drained this cycle
	assign res_ready = !out_valid_q || !out_stall;

	// Hold the result until the downstream side takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = out_q.status;
	assign slot         = out_q.slot;
	assign granted_size = out_q.granted_size;

endmodule

// File: rtl/bfsa_mem.sv
module bfsa_mem #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 33,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic [AW-1:0]    addr,
	input  logic             we,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Single port, read-first, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

// File: rtl/bfsa_ctrl.sv
module bfsa_ctrl
	import bfsa_pkg::*;
#(
	parameter int SLOTS     = 1024,
	parameter int SIZE_BITS = 32,
	parameter int SW        = $clog2(SLOTS)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 func,
	input  logic [31:0]          req_size,
	input  logic [9:0]           handle,
	output logic [SW-1:0]        mem_addr,
	output logic                 mem_we,
	output logic [SIZE_BITS:0]   mem_wdata,
	input  logic [SIZE_BITS:0]   mem_rdata,
	input  logic                 res_ready,
	output logic                 res_valid,
	output res_t                 res
);

	localparam int CW = (SW + 1 > 10) ? SW + 1 : 10;

	alloc_state_t state_q, state_d;

	logic [31:0]          want_q;
	logic [SW-1:0]        handle_q;
	logic [SW:0]          idx_q;
	logic [SW:0]          fill_q;
	logic                 pend_s1;
	logic [SW-1:0]        idx_s1;
	logic                 found_q;
	logic [SIZE_BITS-1:0] best_size_q;
	logic [SW-1:0]        best_idx_q;
	res_t                 res_q;

	logic                 accept;
	logic                 want_fits;
	logic                 handle_known;
	logic                 scan_more;
	logic                 rd_busy;
	logic [SIZE_BITS-1:0] rd_size;
	logic [SIZE_BITS-1:0] want_ext;
	logic                 hit;
	logic                 pool_open;

	assign accept       = in_valid && !in_stall;
	assign want_fits    = (32'(SIZE_BITS'(req_size)) == req_size);
	assign handle_known = (CW'(handle) < CW'(fill_q));
	assign scan_more    = (idx_q < fill_q);
	assign rd_busy      = mem_rdata[SIZE_BITS];
	assign rd_size      = mem_rdata[SIZE_BITS-1:0];
	assign want_ext     = SIZE_BITS'(want_q);
	assign pool_open    = (fill_q < (SW + 1)'(SLOTS));
	assign hit = pend_s1 && !rd_busy && (rd_size >= want_ext) &&
		(!found_q || (rd_size < best_size_q));

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (func == FUNC_FREE) begin
						state_d = handle_known ? ST_FREE_RD : ST_RESP;
					end else if (req_size == 32'd0 || !want_fits) begin
						state_d = ST_RESP;
					end else begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (!scan_more && !pend_s1) begin
					state_d = ST_COMMIT;
				end
			end
			ST_FREE_RD: state_d = ST_RESP;
			ST_COMMIT:  state_d = ST_RESP;
			ST_RESP: begin
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		in_stall  = (state_q != ST_IDLE);
		res_valid = (state_q == ST_RESP) && res_ready;
		res       = res_q;
		mem_addr  = idx_q[SW-1:0];
		mem_we    = 1'b0;
		mem_wdata = {1'b0, rd_size};
		unique case (state_q)
			ST_IDLE: begin
				mem_addr = SW'(handle);
			end
			ST_FREE_RD: begin
				mem_addr  = handle_q;
				mem_we    = 1'b1;
				mem_wdata = {1'b0, rd_size};
			end
			ST_COMMIT: begin
				if (found_q) begin
					mem_addr  = best_idx_q;
					mem_we    = 1'b1;
					mem_wdata = {1'b1, best_size_q};
				end else if (pool_open) begin
					mem_addr  = fill_q[SW-1:0];
					mem_we    = 1'b1;
					mem_wdata = {1'b1, want_ext};
				end
			end
			default: begin
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q  <= '0;
			pend_s1 <= 1'b0;
			found_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			pend_s1 <= (state_q == ST_SCAN) && scan_more;
			if (accept) begin
				idx_q   <= '0;
				found_q <= 1'b0;
			end else if (state_q == ST_SCAN) begin
				if (scan_more) begin
					idx_q <= idx_q + 1'b1;
				end
				if (hit) begin
					found_q <= 1'b1;
				end
			end
			if (state_q == ST_COMMIT && !found_q && pool_open) begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		idx_s1 <= idx_q[SW-1:0];
		if (accept) begin
			want_q   <= req_size;
			handle_q <= SW'(handle);
			if (func == FUNC_FREE) begin
				res_q <= '{status: STAT_UNKNOWN, slot: handle, granted_size: 32'd0};
			end else if (req_size == 32'd0) begin
				res_q <= '{status: STAT_ZERO, slot: 10'd0, granted_size: 32'd0};
			end else begin
				res_q <= '{status: STAT_FULL, slot: 10'd0, granted_size: 32'd0};
			end
		end
		if (state_q == ST_SCAN && hit) begin
			best_size_q <= rd_size;
			best_idx_q  <= idx_s1;
		end
		if (state_q == ST_FREE_RD) begin
			res_q <= '{status: STAT_REUSED, slot: 10'(handle_q),
				granted_size: 32'(rd_size)};
		end
		if (state_q == ST_COMMIT) begin
			if (found_q) begin
				res_q <= '{status: STAT_REUSED, slot: 10'(best_idx_q),
					granted_size: 32'(best_size_q)};
			end else if (pool_open) begin
				res_q <= '{status: STAT_NEW, slot: 10'(fill_q), granted_size: want_q};
			end
		end
	end

endmodule
